// File: rtl/tcfq_pkg.sv
package tcfq_pkg;

    localparam int PAYLOAD_W = 32;
    localparam int STAMP_W   = 6;

    // Operation codes.
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    // Class selector codes.
    localparam logic [1:0] CLASS_ZERO = 2'd0;
    localparam logic [1:0] CLASS_ONE  = 2'd1;
    localparam logic [1:0] CLASS_ANY  = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_BADCLASS = 2'd3;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

endpackage

// File: rtl/tcfq_ram.sv
module tcfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/tcfq_ctrl.sv
module tcfq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output tcfq_pkg::ctrl_cmd_t  cmd
);

    import tcfq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        busy        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // Head words are out of the RAMs now; finish the operation.
                busy        = 1'b1;
                cmd.execute = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/tcfq_dp.sv
module tcfq_dp #(
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tcfq_pkg::ctrl_cmd_t               cmd,
    input  logic                              func,
    input  logic [1:0]                        class_sel,
    input  logic [tcfq_pkg::PAYLOAD_W-1:0]    payload_in,
    output logic                              done,
    output logic [1:0]                        status,
    output logic                              out_class,
    output logic [tcfq_pkg::PAYLOAD_W-1:0]    payload_out
);

    import tcfq_pkg::*;

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int WORDW = STAMP_W + PAYLOAD_W;

    // Captured command word.
    logic                 func_reg;
    logic [1:0]           class_reg;
    logic [PAYLOAD_W-1:0] payload_reg;

    logic [AW-1:0]      zero_head_reg, zero_head_next;
    logic [AW-1:0]      zero_tail_reg, zero_tail_next;
    logic [CW-1:0]      zero_count_reg, zero_count_next;
    logic [AW-1:0]      one_head_reg, one_head_next;
    logic [AW-1:0]      one_tail_reg, one_tail_next;
    logic [CW-1:0]      one_count_reg, one_count_next;
    logic [STAMP_W-1:0] stamp_reg, stamp_next;

    logic                 done_reg, done_next;
    logic [1:0]           status_reg, status_next;
    logic                 out_class_reg, out_class_next;
    logic [PAYLOAD_W-1:0] payload_out_reg, payload_out_next;

    logic                 zero_we, one_we;
    logic [WORDW-1:0]     wdata;
    logic [WORDW-1:0]     zero_rdata, one_rdata;
    logic                 zero_empty, zero_full, one_empty, one_full;
    logic [STAMP_W-1:0]   stamp_diff;
    logic                 pick_valid, pick_one;

    assign wdata = {stamp_reg, payload_reg};

    // The RAMs read the head entries on every clock, so the head words are
    // ready in the cycle after a command is captured.
    tcfq_ram #(
        .WIDTH (WORDW),
        .DEPTH (DEPTH)
    ) u_zero_ram (
        .clk   (clk),
        .we    (zero_we),
        .waddr (zero_tail_reg),
        .wdata (wdata),
        .raddr (zero_head_reg),
        .rdata (zero_rdata)
    );

    tcfq_ram #(
        .WIDTH (WORDW),
        .DEPTH (DEPTH)
    ) u_one_ram (
        .clk   (clk),
        .we    (one_we),
        .waddr (one_tail_reg),
        .wdata (wdata),
        .raddr (one_head_reg),
        .rdata (one_rdata)
    );

    assign zero_empty = (zero_count_reg == '0);
    assign one_empty  = (one_count_reg == '0);
    assign zero_full  = (zero_count_reg == CW'(DEPTH));
    assign one_full   = (one_count_reg == CW'(DEPTH));

    // Wrap-aware age compare: class zero is older when the difference is negative.
    assign stamp_diff = zero_rdata[WORDW-1 -: STAMP_W] - one_rdata[WORDW-1 -: STAMP_W];

    always_comb
    begin
        zero_head_next   = zero_head_reg;
        zero_tail_next   = zero_tail_reg;
        zero_count_next  = zero_count_reg;
        one_head_next    = one_head_reg;
        one_tail_next    = one_tail_reg;
        one_count_next   = one_count_reg;
        stamp_next       = stamp_reg;
        zero_we          = 1'b0;
        one_we           = 1'b0;
        pick_valid       = 1'b0;
        pick_one         = 1'b0;
        done_next        = cmd.execute;
        status_next      = status_reg;
        out_class_next   = out_class_reg;
        payload_out_next = payload_out_reg;

        if (cmd.execute)
        begin
            status_next      = ST_BADCLASS;
            out_class_next   = 1'b0;
            payload_out_next = '0;
            if (func_reg == FUNC_ENQ)
            begin
                case (class_reg)
                    CLASS_ZERO:
                    begin
                        if (zero_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            status_next     = ST_OK;
                            zero_we         = 1'b1;
                            zero_tail_next  = (zero_tail_reg == AW'(DEPTH - 1)) ? '0
                                              : zero_tail_reg + 1'b1;
                            zero_count_next = zero_count_reg + 1'b1;
                            stamp_next      = stamp_reg + 1'b1;
                        end
                    end
                    CLASS_ONE:
                    begin
                        out_class_next = 1'b1;
                        if (one_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            status_next    = ST_OK;
                            one_we         = 1'b1;
                            one_tail_next  = (one_tail_reg == AW'(DEPTH - 1)) ? '0
                                             : one_tail_reg + 1'b1;
                            one_count_next = one_count_reg + 1'b1;
                            stamp_next     = stamp_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        status_next = ST_BADCLASS;
                    end
                endcase
            end
            else
            begin
                case (class_reg)
                    CLASS_ZERO:
                    begin
                        pick_valid = 1'b1;
                        pick_one   = 1'b0;
                    end
                    CLASS_ONE:
                    begin
                        pick_valid = 1'b1;
                        pick_one   = 1'b1;
                    end
                    CLASS_ANY:
                    begin
                        if (zero_empty && one_empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            pick_valid = 1'b1;
                            if (zero_empty)
                            begin
                                pick_one = 1'b1;
                            end
                            else if (one_empty)
                            begin
                                pick_one = 1'b0;
                            end
                            else
                            begin
                                pick_one = ~stamp_diff[STAMP_W-1];
                            end
                        end
                    end
                    default:
                    begin
                        status_next = ST_BADCLASS;
                    end
                endcase

                if (pick_valid)
                begin
                    out_class_next = pick_one;
                    if (!pick_one)
                    begin
                        if (zero_empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            status_next      = ST_OK;
                            payload_out_next = zero_rdata[PAYLOAD_W-1:0];
                            zero_head_next   = (zero_head_reg == AW'(DEPTH - 1)) ? '0
                                               : zero_head_reg + 1'b1;
                            zero_count_next  = zero_count_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        if (one_empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            status_next      = ST_OK;
                            payload_out_next = one_rdata[PAYLOAD_W-1:0];
                            one_head_next    = (one_head_reg == AW'(DEPTH - 1)) ? '0
                                               : one_head_reg + 1'b1;
                            one_count_next   = one_count_reg - 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg    <= func;
            class_reg   <= class_sel;
            payload_reg <= payload_in;
        end
        status_reg      <= status_next;
        out_class_reg   <= out_class_next;
        payload_out_reg <= payload_out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_head_reg  <= '0;
            zero_tail_reg  <= '0;
            zero_count_reg <= '0;
            one_head_reg   <= '0;
            one_tail_reg   <= '0;
            one_count_reg  <= '0;
            stamp_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            zero_head_reg  <= zero_head_next;
            zero_tail_reg  <= zero_tail_next;
            zero_count_reg <= zero_count_next;
            one_head_reg   <= one_head_next;
            one_tail_reg   <= one_tail_next;
            one_count_reg  <= one_count_next;
            stamp_reg      <= stamp_next;
            done_reg       <= done_next;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign out_class   = out_class_reg;
    assign payload_out = payload_out_reg;

endmodule

// File: rtl/two_class_fifo_oldest_first.sv
// Channel   Direction  Handshake            Word
// -------   ---------  -------------------  ---------------------------------
// command   in         start high, busy low func, class_sel, payload_in
// result    out        done, one cycle      status, out_class, payload_out
//
// Every command passes through an accept cycle, in which both RAMs read their
// head entries, and then an execute cycle, in which pointers, counts and the
// stamp counter update. The result shows on the cycle after the execute cycle,
// and a new command may be accepted in that same cycle.
// Reset is asynchronous and active low; it clears pointers, counts and the
// stamp counter at once, with no clearing pass over the RAMs.
// The receiver cannot stall: done marks each result for exactly one cycle.
module two_class_fifo_oldest_first #(
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              func,
    input  logic [1:0]                        class_sel,
    input  logic [tcfq_pkg::PAYLOAD_W-1:0]    payload_in,
    output logic                              done,
    output logic [1:0]                        status,
    output logic                              out_class,
    output logic [tcfq_pkg::PAYLOAD_W-1:0]    payload_out
);

    import tcfq_pkg::*;

    // Commands from the sequencer: capture the command word on accept, then
    // execute it once the head words are out of the RAMs.
    ctrl_cmd_t cmd;

    tcfq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    // The datapath holds two circular queues, each in its own RAM with a
    // stamp stored next to every payload. An "any" dequeue compares the two
    // head stamps modulo the stamp width and takes the older head, or the
    // only head that exists.
    tcfq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .func        (func),
        .class_sel   (class_sel),
        .payload_in  (payload_in),
        .done        (done),
        .status      (status),
        .out_class   (out_class),
        .payload_out (payload_out)
    );

endmodule
